[src/i2cbr_pkg.sv]
// Package for the I2C bus recovery sequencer.
// Holds the phase encoding, register indexes, field widths and parameter defaults.
// No dependencies.
`timescale 1ns / 1ps

package i2cbr_pkg;

  // Default number of recovery clock pulses
  localparam int PULSES_DEF = 9;

  // Register defaults and widths
  localparam int          REG_W            = 8;
  localparam int          TICK_W           = 9;
  localparam int          CFG_INDEX_W      = 1;
  localparam logic [7:0]  HALF_PERIOD_RST  = 8'd5;
  localparam logic [7:0]  STRETCH_POLLS_RST = 8'd50;

  // Register indexes on the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_HALF_PERIOD   = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_STRETCH_POLLS = 1'b1;

  // Sequencer phases, one-hot
  typedef enum logic [7:0] {
    PH_IDLE      = 8'b0000_0001,
    PH_WAIT      = 8'b0000_0010,
    PH_LOW       = 8'b0000_0100,
    PH_HIGH      = 8'b0000_1000,
    PH_STOP_SCL  = 8'b0001_0000,
    PH_STOP_SDA  = 8'b0010_0000,
    PH_STOP_RISE = 8'b0100_0000,
    PH_STOP_END  = 8'b1000_0000
  } phase_t;

endpackage

[src/i2c_bus_recovery_sequencer_core.sv]
// I2C bus recovery sequencer: the result of an input transfer is registered and shown in the next cycle;
// it takes one tick per clock while the output is not stalled; the output register frees in the cycle it is taken.
// The phase sequencer and its tick, pulse and poll counters advance once per transfer.
// Reset (rst, synchronous): idle, both lines released, half_period 5, stretch_polls 50.
// Depends on i2cbr_pkg.
`timescale 1ns / 1ps

module i2c_bus_recovery_sequencer_core
  import i2cbr_pkg::*;
#(
  parameter int PULSES = PULSES_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // configuration writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]       cfg_data,
  // tick input
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   start_req,
  input  logic                   scl_level,
  input  logic                   sda_level,
  // result output
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   scl_pull_low,
  output logic                   sda_pull_low,
  output logic                   busy_res,
  output logic                   done_res,
  output logic                   bus_free
);

  localparam int PULSE_W = $clog2(PULSES + 1);

  // Configuration registers
  logic [REG_W-1:0]  half_period;
  logic [REG_W-1:0]  stretch_polls;

  // Sequencer state
  phase_t            phase, phase_next;
  logic [PULSE_W-1:0] pulse_count, pulse_count_next;
  logic [TICK_W-1:0] tick_count, tick_count_next;
  logic [REG_W-1:0]  poll_count, poll_count_next;
  logic              scl_drive, scl_drive_next;
  logic              sda_drive, sda_drive_next;
  logic              done_next, free_next;

  // Helpers for the stretch check
  logic [REG_W-1:0]   half_ticks;
  logic [TICK_W-1:0]  half_load;
  logic [TICK_W-1:0]  full_load;
  logic [REG_W-1:0]   check_poll;
  logic [PULSE_W-1:0] check_pulse;
  logic               stretch_pass;
  logic               in_xfer;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid & out_stall;
  assign in_xfer   = in_valid & ~in_stall;

  // Take register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      half_period   <= HALF_PERIOD_RST;
      stretch_polls <= STRETCH_POLLS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_HALF_PERIOD:   half_period   <= cfg_data;
        REG_STRETCH_POLLS: stretch_polls <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp the half period and form the count loads
  assign half_ticks = (half_period == '0) ? REG_W'(1) : half_period;
  assign half_load  = {1'b0, half_ticks} - TICK_W'(1);
  assign full_load  = {half_ticks, 1'b0} - TICK_W'(1);

  // A check after a high half period starts with a fresh poll count and the next pulse
  assign check_poll   = (phase == PH_HIGH) ? '0 : poll_count;
  assign check_pulse  = (phase == PH_HIGH) ? pulse_count + PULSE_W'(1) : pulse_count;
  assign stretch_pass = (check_poll >= stretch_polls) || scl_level;

  // Next state and result for one tick
  always_comb begin
    phase_next       = phase;
    pulse_count_next = pulse_count;
    tick_count_next  = tick_count;
    poll_count_next  = poll_count;
    scl_drive_next   = scl_drive;
    sda_drive_next   = sda_drive;
    done_next        = 1'b0;
    free_next        = 1'b0;

    if (phase != PH_IDLE && tick_count != '0) begin
      tick_count_next = tick_count - TICK_W'(1);
    end else begin
      case (phase)
        PH_WAIT, PH_HIGH: begin
          pulse_count_next = check_pulse;
          if (stretch_pass) begin
            scl_drive_next  = 1'b1;
            poll_count_next = check_poll;
            tick_count_next = half_load;
            phase_next      = (check_pulse < PULSE_W'(PULSES)) ? PH_LOW : PH_STOP_SCL;
          end else begin
            poll_count_next = check_poll + REG_W'(1);
            tick_count_next = full_load;
            phase_next      = PH_WAIT;
          end
        end
        PH_LOW: begin
          scl_drive_next  = 1'b0;
          tick_count_next = half_load;
          phase_next      = PH_HIGH;
        end
        PH_STOP_SCL: begin
          sda_drive_next  = 1'b1;
          tick_count_next = half_load;
          phase_next      = PH_STOP_SDA;
        end
        PH_STOP_SDA: begin
          scl_drive_next  = 1'b0;
          tick_count_next = half_load;
          phase_next      = PH_STOP_RISE;
        end
        PH_STOP_RISE: begin
          sda_drive_next  = 1'b0;
          tick_count_next = half_load;
          phase_next      = PH_STOP_END;
        end
        PH_STOP_END: begin
          done_next       = 1'b1;
          free_next       = scl_level & sda_level;
          tick_count_next = '0;
          phase_next      = PH_IDLE;
        end
        default: begin
          phase_next     = PH_IDLE;
          scl_drive_next = 1'b0;
          sda_drive_next = 1'b0;
          if (start_req) begin
            phase_next       = PH_WAIT;
            pulse_count_next = '0;
            poll_count_next  = '0;
            tick_count_next  = '0;
          end
        end
      endcase
    end
  end

  // Advance the sequencer on each input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      pulse_count <= '0;
      tick_count  <= '0;
      poll_count  <= '0;
      scl_drive   <= 1'b0;
      sda_drive   <= 1'b0;
    end else if (in_xfer) begin
      phase       <= phase_next;
      pulse_count <= pulse_count_next;
      tick_count  <= tick_count_next;
      poll_count  <= poll_count_next;
      scl_drive   <= scl_drive_next;
      sda_drive   <= sda_drive_next;
    end
  end

  // Hold the result until the output transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_xfer) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      scl_pull_low <= scl_drive_next;
      sda_pull_low <= sda_drive_next;
      busy_res     <= (phase_next != PH_IDLE);
      done_res     <= done_next;
      bus_free     <= free_next;
    end
  end

`ifndef ASSERT_OFF
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> !busy_res)
    else $error("done reported while still busy");

  a_free_with_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && bus_free |-> done_res)
    else $error("bus_free reported without done");

  a_idle_released: assert property (@(posedge clk) disable iff (rst)
    phase == PH_IDLE |-> !scl_drive && !sda_drive && tick_count == '0)
    else $error("lines driven or count running while idle");

  a_sda_in_stop: assert property (@(posedge clk) disable iff (rst)
    sda_drive |-> phase == PH_STOP_SDA || phase == PH_STOP_RISE)
    else $error("SDA driven outside the STOP build");
`endif

endmodule
